[hw/rtl/mmq_pkg.sv]
// ----------------------------------------------------------------------------
// mmq_pkg - shared definitions of the min-max uint8 quantizer
// Holds the command codes, code-byte constants and the range control struct.
// ----------------------------------------------------------------------------
package mmq_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CODE_BITS       = 8;
    localparam int CODE_MAX        = 255;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_OBSERVE = 2'd1,
        CMD_QUANT   = 2'd2,
        CMD_DEQUANT = 2'd3
    } t_cmd;

    typedef struct packed {
        logic clear;
        logic observe;
    } t_range_ctl;

endpackage

[hw/rtl/mmq_in_if.sv]
// ----------------------------------------------------------------------------
// mmq_in_if - input item channel
// Valid/ready channel carrying command, sample and code of one item.
// ----------------------------------------------------------------------------
interface mmq_in_if #(
    parameter int SAMPLE_BITS = mmq_pkg::SAMPLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [1:0]                          command;
    logic signed [SAMPLE_BITS-1:0]       sample;
    logic [mmq_pkg::CODE_BITS-1:0]       code;

    modport source (output valid, output command, output sample, output code, input ready);
    modport sink   (input valid, input command, input sample, input code, output ready);
endinterface

[hw/rtl/mmq_out_if.sv]
// ----------------------------------------------------------------------------
// mmq_out_if - result item channel
// Valid/ready channel carrying the fields of one result item.
// ----------------------------------------------------------------------------
interface mmq_out_if #(
    parameter int SAMPLE_BITS = mmq_pkg::SAMPLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [mmq_pkg::CODE_BITS-1:0]       quantized;
    logic signed [SAMPLE_BITS-1:0]       restored;
    logic                                clipped;
    logic                                range_valid;

    modport source (output valid, output quantized, output restored, output clipped,
                    output range_valid, input ready);
    modport sink   (input valid, input quantized, input restored, input clipped,
                    input range_valid, output ready);
endinterface

[hw/rtl/mmq_range.sv]
// ----------------------------------------------------------------------------
// mmq_range - running minimum / maximum tracker
// Widens the [low, high] window on observe, empties it on clear.
// ----------------------------------------------------------------------------
module mmq_range #(
    parameter int SAMPLE_BITS = mmq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmq_pkg::t_range_ctl           i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_low,
    output logic signed [SAMPLE_BITS-1:0] o_high,
    output logic                          o_seen
);

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_low;
    logic signed [SAMPLE_BITS-1:0] r_high;
    logic                          r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_low  <= MOST_POS;
            r_high <= MOST_NEG;
            r_seen <= 1'b0;
        end else if (i_ctl.observe) begin
            if (!r_seen || (i_sample < r_low)) begin
                r_low <= i_sample;
            end
            if (!r_seen || (i_sample > r_high)) begin
                r_high <= i_sample;
            end
            r_seen <= 1'b1;
        end
    end

    assign o_low  = r_low;
    assign o_high = r_high;
    assign o_seen = r_seen;

endmodule

[hw/rtl/mmq_div.sv]
// ----------------------------------------------------------------------------
// mmq_div - bit-serial restoring divider
// Shifts the dividend out one bit per cycle and the quotient in behind it.
// ----------------------------------------------------------------------------
module mmq_div #(
    parameter int SAMPLE_BITS = mmq_pkg::SAMPLE_BITS_DEF,
    localparam int CW = $clog2(SAMPLE_BITS + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_rem,
    input  logic [SAMPLE_BITS-1:0] i_shf,
    input  logic [SAMPLE_BITS-1:0] i_den,
    input  logic [CW-1:0]          i_steps,
    output logic                   o_busy,
    output logic [SAMPLE_BITS-1:0] o_quot
);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [SAMPLE_BITS-1:0] r_shf;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [CW-1:0]          r_cnt;

    logic [SAMPLE_BITS:0]   w_trial;
    logic [SAMPLE_BITS:0]   w_diff;
    logic                   w_ge;

    // Partial remainder stays below the divisor, so one extra bit covers the trial.
    assign w_trial = {r_rem, r_shf[SAMPLE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
            r_rem <= i_rem;
            r_shf <= i_shf;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
            r_rem <= w_ge ? w_diff[SAMPLE_BITS-1:0] : w_trial[SAMPLE_BITS-1:0];
            r_shf <= {r_shf[SAMPLE_BITS-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_shf;

endmodule

[hw/rtl/minmax_uint8_quantizer.sv]
// ----------------------------------------------------------------------------
// minmax_uint8_quantizer - asymmetric min-max uint8 quantizer
// Tracks a signed Q15.16 value window and maps samples to byte codes and back.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake     | Payload
//  ---------+-----+---------------+--------------------------------------------
//  i_in     | in  | valid / ready | command[1:0], sample[W-1:0], code[7:0]
//  o_out    | out | valid / ready | quantized[7:0], restored[W-1:0], clipped,
//           |     |               | range_valid
//
//  Path per item: clear and observe go from S_IDLE to S_FIN; a quantize that
//  needs no divide, or a quantize or dequantize on an empty window, passes S_CMP
//  only; a quantize with a divide (8 quotient bits) and a dequantize (SAMPLE_BITS
//  quotient bits) pass S_CMP, S_MUL and S_DIV, where mmq_div forms one quotient bit per cycle.
//  Reset (synchronous, active low) empties the window and drops any result.
//  A result waits in the output register; the next item is taken meanwhile,
//  and only the write of its own result waits for the register to drain.
//
module minmax_uint8_quantizer #(
    parameter int SAMPLE_BITS = mmq_pkg::SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmq_in_if.sink    i_in,
    mmq_out_if.source o_out
);

    localparam int W  = SAMPLE_BITS;
    localparam int CB = mmq_pkg::CODE_BITS;
    localparam int N  = W + CB;                // width of a dividend
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    mmq_pkg::t_cmd       r_cmd;
    logic signed [W-1:0] r_x;
    logic [CB-1:0]       r_code;
    logic [W-1:0]        r_span;
    logic [W-1:0]        r_diff;
    logic [CB-1:0]       r_q;
    logic                r_clip;
    logic                r_use_div;

    logic                r_out_valid;
    logic [CB-1:0]       r_out_q;
    logic signed [W-1:0] r_out_rest;
    logic                r_out_clip;
    logic                r_out_rv;

    logic                 w_accept;
    mmq_pkg::t_cmd        w_in_cmd;
    mmq_pkg::t_range_ctl  w_rng_ctl;
    logic signed [W-1:0]  w_low;
    logic signed [W-1:0]  w_high;
    logic                 w_seen;
    logic                 w_lt;
    logic                 w_gt;
    logic                 w_flat;
    logic [N-1:0]         w_num_q;
    logic [N-1:0]         w_num_d;
    logic [W-1:0]         w_div_rem;
    logic [W-1:0]         w_div_shf;
    logic [W-1:0]         w_div_den;
    logic [CW-1:0]        w_div_steps;
    logic                 w_div_start;
    logic                 w_div_busy;
    logic [W-1:0]         w_quot;
    logic                 w_out_free;
    logic                 w_out_load;

    // ---- input side --------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_in_cmd   = mmq_pkg::t_cmd'(i_in.command);

    // Clear and observe act on the window at the edge that takes the item.
    assign w_rng_ctl.clear   = w_accept && (w_in_cmd == mmq_pkg::CMD_CLEAR);
    assign w_rng_ctl.observe = w_accept && (w_in_cmd == mmq_pkg::CMD_OBSERVE);

    mmq_range #(
        .SAMPLE_BITS (W)
    ) u_range (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_rng_ctl),
        .i_sample (i_in.sample),
        .o_low    (w_low),
        .o_high   (w_high),
        .o_seen   (w_seen)
    );

    // ---- window tests, evaluated in S_CMP -----------------------------------
    assign w_lt   = (r_x < w_low);
    assign w_gt   = (r_x > w_high);
    assign w_flat = (w_high == w_low);

    // ---- dividend set-up, evaluated in S_MUL --------------------------------
    // Quantize: (x - low) * 255 as (d << 8) - d; quotient fits 8 bits.
    assign w_num_q = (N'(r_diff) << CB) - N'(r_diff);
    // Dequantize: code * span; quotient fits W bits, divisor is 255.
    assign w_num_d = N'(r_code) * N'(r_span);

    always_comb begin
        if (r_cmd == mmq_pkg::CMD_QUANT) begin
            // Top W bits are already below the span: start with them as remainder.
            w_div_rem   = w_num_q[N-1:CB];
            w_div_shf   = W'(w_num_q[CB-1:0]) << (W - CB);
            w_div_den   = r_span;
            w_div_steps = CW'(CB);
        end else begin
            w_div_rem   = W'(w_num_d[N-1:W]);
            w_div_shf   = w_num_d[W-1:0];
            w_div_den   = W'(mmq_pkg::CODE_MAX);
            w_div_steps = CW'(W);
        end
    end

    assign w_div_start = (r_state == S_MUL);

    mmq_div #(
        .SAMPLE_BITS (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_shf   (w_div_shf),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // ---- sequencer and output register --------------------------------------
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = (r_state == S_FIN) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid for a new result; drop it once the result is taken.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd     <= w_in_cmd;
                        r_x       <= i_in.sample;
                        r_code    <= i_in.code;
                        r_q       <= '0;
                        r_clip    <= 1'b0;
                        r_use_div <= 1'b0;
                        if (w_in_cmd == mmq_pkg::CMD_QUANT ||
                            w_in_cmd == mmq_pkg::CMD_DEQUANT) begin
                            r_state <= S_CMP;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_CMP: begin
                    r_span <= W'(w_high - w_low);
                    r_diff <= W'(r_x - w_low);
                    if (!w_seen) begin
                        r_state <= S_FIN;
                    end else if (r_cmd == mmq_pkg::CMD_DEQUANT) begin
                        r_use_div <= 1'b1;
                        r_state   <= S_MUL;
                    end else if (w_lt) begin
                        r_clip  <= 1'b1;
                        r_state <= S_FIN;
                    end else if (w_gt) begin
                        // Above a flat window the code stays 0.
                        r_clip  <= 1'b1;
                        r_q     <= w_flat ? '0 : CB'(mmq_pkg::CODE_MAX);
                        r_state <= S_FIN;
                    end else if (w_flat) begin
                        r_state <= S_FIN;
                    end else begin
                        r_use_div <= 1'b1;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_clip  <= r_clip;
                        r_out_rv    <= w_seen;
                        if (r_use_div && r_cmd == mmq_pkg::CMD_QUANT) begin
                            r_out_q <= w_quot[CB-1:0];
                        end else begin
                            r_out_q <= r_q;
                        end
                        if (r_use_div && r_cmd == mmq_pkg::CMD_DEQUANT) begin
                            r_out_rest <= w_low + $signed(w_quot);
                        end else begin
                            r_out_rest <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.quantized   = r_out_q;
    assign o_out.restored    = r_out_rest;
    assign o_out.clipped     = r_out_clip;
    assign o_out.range_valid = r_out_rv;

    // ---- assertions ----------------------------------------------------------
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_cmd == mmq_pkg::CMD_CLEAR) |=> !w_seen)
        else $error("window not emptied by clear");

    a_observe_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_cmd == mmq_pkg::CMD_OBSERVE) |=> (w_seen && (w_low <= w_high)))
        else $error("window inconsistent after observe");

    a_clip_needs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> r_out_rv)
        else $error("clipped result without a valid range");

    a_quant_fits_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !w_div_busy && r_cmd == mmq_pkg::CMD_QUANT)
            |-> ((w_quot >> CB) == '0))
        else $error("quantize quotient exceeds one byte");

endmodule

[tb/sv/tb_minmax_uint8_quantizer.sv]
// ----------------------------------------------------------------------------
// tb_minmax_uint8_quantizer - self-checking bench of the min-max quantizer
// Feeds directed and random clear/observe/quantize/dequantize items, keeps
// its own window and divide arithmetic, and checks every result item field
// by field under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_minmax_uint8_quantizer;

    localparam int W                = mmq_pkg::SAMPLE_BITS_DEF;
    localparam int CB               = mmq_pkg::CODE_BITS;
    localparam int RANDOM_PER_PHASE = 132;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LIMIT_CYCLES     = 400_000;

    localparam logic [CB-1:0]   CODE_TOP = CB'(mmq_pkg::CODE_MAX);
    localparam longint unsigned CODE_DIV = 64'(mmq_pkg::CODE_MAX);

    typedef logic signed [W-1:0] t_sample;

    localparam t_sample SAMPLE_MAXV = {1'b0, {(W-1){1'b1}}};
    localparam t_sample SAMPLE_MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct {
        mmq_pkg::t_cmd command;
        t_sample       sample;
        logic [CB-1:0] code;
    } t_item;

    typedef struct {
        logic [CB-1:0] quantized;
        t_sample       restored;
        logic          clipped;
        logic          range_valid;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mmq_in_if  #(.SAMPLE_BITS(W)) in_if ();
    mmq_out_if #(.SAMPLE_BITS(W)) out_if ();

    minmax_uint8_quantizer #(.SAMPLE_BITS(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Items waiting to be offered, and result items still owed by the block.
    t_item   pending_items[$];
    t_result owed_results[$];

    // Window kept alongside the block.
    t_sample win_low  = SAMPLE_MAXV;
    t_sample win_high = SAMPLE_MINV;
    logic    win_seen = 1'b0;

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        in_taken       = 1'b0;

    // Long receiver hold-off: the stimulus flips hold_req, the ready
    // process counts the stretch out on its own.
    logic        hold_req  = 1'b0;
    logic        hold_ack  = 1'b0;
    int unsigned hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one item to the window and work out its result item.
    // All arithmetic is exact in 64 bits: (x - low) * 255 and code * span
    // both fit comfortably for a 32-bit sample.
    // ------------------------------------------------------------------------
    function automatic t_result window_apply(t_item it);
        t_result         res;
        longint          offset;
        longint unsigned span;
        longint unsigned quot;
        res = '{default: '0};
        span = longint'(win_high) - longint'(win_low);
        case (it.command)
            mmq_pkg::CMD_CLEAR: begin
                // Empty the window back to its reset state.
                win_low  = SAMPLE_MAXV;
                win_high = SAMPLE_MINV;
                win_seen = 1'b0;
            end
            mmq_pkg::CMD_OBSERVE: begin
                // Widen the window; the first sample after a clear sets both ends.
                if (!win_seen || it.sample < win_low)  win_low  = it.sample;
                if (!win_seen || it.sample > win_high) win_high = it.sample;
                win_seen = 1'b1;
            end
            mmq_pkg::CMD_QUANT: begin
                // Nothing observed: all zero. Outside the window: clip to
                // the nearest end, except a flat window, which always gives 0.
                if (win_seen) begin
                    if (it.sample < win_low) begin
                        res.clipped = 1'b1;
                    end else if (it.sample > win_high) begin
                        res.clipped   = 1'b1;
                        res.quantized = (win_high == win_low) ? '0 : CODE_TOP;
                    end else if (win_high != win_low) begin
                        offset = longint'(it.sample) - longint'(win_low);
                        quot   = ($unsigned(offset) * CODE_DIV) / span;
                        res.quantized = (quot > CODE_DIV) ? CODE_TOP : quot[CB-1:0];
                    end
                end
            end
            mmq_pkg::CMD_DEQUANT: begin
                // Map the byte back onto the window; a flat window gives low.
                if (win_seen) begin
                    quot   = (64'(it.code) * span) / CODE_DIV;
                    offset = longint'(win_low) + longint'(quot);
                    res.restored = offset[W-1:0];
                end
            end
            default: ;
        endcase
        res.range_valid = win_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge; hold an item until taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_items
        t_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // hold the item on offer
        end else if (pending_items.size() == 0 ||
                     $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
        end else begin
            nxt = pending_items.pop_front();
            in_if.valid   <= 1'b1;
            in_if.command <= nxt.command;
            in_if.sample  <= nxt.sample;
            in_if.code    <= nxt.code;
        end
    end

    // Receiver ready: long hold-off when requested, else random stalls.
    always @(negedge i_clk) begin : drive_ready
        if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_left    <= LONG_HOLD;
            hold_ack     <= hold_req;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on the rising edge, check the result item first, then record
    // the accepted input item and what it should produce.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_result owed;
        t_item   taken;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (owed_results.size() == 0) begin
                $error("result item with none owed: quantized %0d restored %0d",
                       out_if.quantized, out_if.restored);
                fail_count++;
            end else begin
                owed = owed_results.pop_front();
                if (out_if.quantized !== owed.quantized) begin
                    $error("quantized: expected %0d, got %0d",
                           owed.quantized, out_if.quantized);
                    fail_count++;
                end
                if (out_if.restored !== owed.restored) begin
                    $error("restored: expected %0d, got %0d",
                           owed.restored, out_if.restored);
                    fail_count++;
                end
                if (out_if.clipped !== owed.clipped) begin
                    $error("clipped: expected %0b, got %0b",
                           owed.clipped, out_if.clipped);
                    fail_count++;
                end
                if (out_if.range_valid !== owed.range_valid) begin
                    $error("range_valid: expected %0b, got %0b",
                           owed.range_valid, out_if.range_valid);
                    fail_count++;
                end
            end
        end
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            taken.command = mmq_pkg::t_cmd'(in_if.command);
            taken.sample  = in_if.sample;
            taken.code    = in_if.code;
            owed_results.push_back(window_apply(taken));
            items_accepted++;
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(mmq_pkg::t_cmd cmd, t_sample smp, logic [CB-1:0] cd);
        t_item it;
        it.command = cmd;
        it.sample  = smp;
        it.code    = cd;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [CB-1:0] rand_code();
        return CB'($urandom);
    endfunction

    function automatic t_sample rand_sample();
        return W'($urandom);
    endfunction

    // Pick a sample around centre with a spread of about 2**(bits-1),
    // saturated to the sample range so that the extremes turn up too.
    function automatic t_sample near_sample(longint centre, int unsigned bits);
        longint v;
        if (bits == 0) begin
            v = centre;
        end else begin
            if (bits > W) bits = W;
            v = centre + (longint'(int'($urandom)) >>> (W - bits));
        end
        if (v > longint'(SAMPLE_MAXV)) return SAMPLE_MAXV;
        if (v < longint'(SAMPLE_MINV)) return SAMPLE_MINV;
        return v[W-1:0];
    endfunction

    // Directed items: empty window, flat window, full-range window, a
    // narrow window with samples either side, and every code extreme.
    task automatic queue_directed();
        queue_item(mmq_pkg::CMD_CLEAR,   rand_sample(), rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sh0000_1234, rand_code());
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'd200);
        queue_item(mmq_pkg::CMD_OBSERVE, 32'sh0005_0000, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sh0005_0000, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sh0006_0000, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sh0004_0000, rand_code());
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'd255);
        queue_item(mmq_pkg::CMD_OBSERVE, SAMPLE_MINV, rand_code());
        queue_item(mmq_pkg::CMD_OBSERVE, SAMPLE_MAXV, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   SAMPLE_MINV, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   SAMPLE_MAXV, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   '0, rand_code());
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'd0);
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'd255);
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'h55);
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'hAA);
        queue_item(mmq_pkg::CMD_CLEAR,   rand_sample(), rand_code());
        queue_item(mmq_pkg::CMD_OBSERVE, -32'sd3, rand_code());
        queue_item(mmq_pkg::CMD_OBSERVE, 32'sd7, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   -32'sd4, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sd8, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sd2, rand_code());
        queue_item(mmq_pkg::CMD_QUANT,   32'sd7, rand_code());
        queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), 8'd128);
    endtask

    // One random burst: mostly a clear, a few observes around a centre and
    // then quantize/dequantize items against that window; now and then
    // plain noise, or a burst that widens the old window without a clear.
    task automatic queue_burst();
        longint      centre;
        int unsigned spread_bits;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                queue_item(mmq_pkg::t_cmd'($urandom_range(0, 3)), rand_sample(),
                           rand_code());
        end else begin
            if ($urandom_range(0, 3) != 0)
                queue_item(mmq_pkg::CMD_CLEAR, rand_sample(), rand_code());
            centre      = longint'(int'($urandom));
            spread_bits = $urandom_range(0, W);
            repeat ($urandom_range(1, 6))
                queue_item(mmq_pkg::CMD_OBSERVE, near_sample(centre, spread_bits),
                           rand_code());
            repeat ($urandom_range(2, 12)) begin
                case ($urandom_range(0, 9))
                    0:       queue_item(mmq_pkg::CMD_QUANT, rand_sample(), rand_code());
                    1, 2, 3: queue_item(mmq_pkg::CMD_DEQUANT, rand_sample(), rand_code());
                    default: queue_item(mmq_pkg::CMD_QUANT,
                                        near_sample(centre, spread_bits + 1),
                                        rand_code());
                endcase
            end
        end
    endtask

    // Wait until every queued item is taken and every result item has come.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_queued || owed_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Run: reset, then four phases with different sender idling and receiver stalling, each drained before the next.
    // ------------------------------------------------------------------------
    initial begin : run_test
        int unsigned target;
        in_if.valid   = 1'b0;
        in_if.command = mmq_pkg::CMD_CLEAR;
        in_if.sample  = '0;
        in_if.code    = '0;
        out_if.ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 0) queue_directed();
            // Back up the block with the sender still offering items.
            if (ph == 0 || ph == 3) hold_req = !hold_req;
            target = items_queued + RANDOM_PER_PHASE;
            while (items_queued < target) queue_burst();
            wait_drained();
        end

        // Let any stray result item show itself before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
